// ----- design/dpg_pkg.sv -----
`default_nettype none
package dpg_pkg;

  localparam int NUM_VOICES = 8;
  localparam int PHRASE_LEN = 16;
  localparam logic [31:0] SEED_ZERO_SUB = 32'h9e3779b9;
  localparam logic [24:0] ONE24 = 25'h100_0000;
  // ceil(2^37 / 100): x / 100 == (x * DIV100_MUL) >> 37 for any 32-bit x
  localparam logic [31:0] DIV100_MUL = 32'h51EB_851F;

  // Configuration register indexes
  localparam logic [2:0] REG_STYLE   = 3'd0;
  localparam logic [2:0] REG_DENSITY = 3'd1;
  localparam logic [2:0] REG_TENSION = 3'd2;
  localparam logic [2:0] REG_KIT     = 3'd3;
  localparam logic [2:0] REG_STEPS   = 3'd4;

  // Slot marks of one template row
  typedef struct packed {
    logic [15:0] anchor;
    logic [15:0] tension;
    logic [15:0] fill;
  } tmpl_row_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // load seed, clear mask, compute chances
    logic roll;      // advance generator and test one step
    logic row_done;  // present the finished row
    logic [2:0] voice;
    logic [6:0] step;
  } dp_cmd_t;

  function automatic tmpl_row_t tmpl_lookup(input logic [2:0] st, input logic [2:0] v);
    logic [47:0] r;
    begin
      r = '0;
      case (st)
        3'd1: case (v)
          3'd0: r = {16'h0401, 16'h2108, 16'h8040};
          3'd1: r = {16'h1010, 16'h4080, 16'h0404};
          3'd2: r = {16'h1000, 16'h0080, 16'h0000};
          3'd3: r = {16'h5555, 16'hAAAA, 16'hFFFF};
          3'd4: r = {16'h8080, 16'h0408, 16'h2000};
          3'd5: r = {16'h0000, 16'h4000, 16'h8040};
          3'd6: r = {16'h0001, 16'h8000, 16'h0000};
          default: r = {16'h0000, 16'h0404, 16'h4040};
        endcase
        3'd2: case (v)
          3'd0: r = {16'h1111, 16'h4000, 16'h0404};
          3'd1: r = {16'h1010, 16'h8000, 16'h0000};
          3'd2: r = {16'h1010, 16'h0400, 16'h0040};
          3'd3: r = {16'h4444, 16'hAAAA, 16'h5555};
          3'd4: r = {16'h4040, 16'h8000, 16'h0400};
          3'd5: r = {16'h0000, 16'h4000, 16'h0080};
          3'd6: r = {16'h0001, 16'h1000, 16'h0000};
          default: r = {16'h0000, 16'h0808, 16'h4040};
        endcase
        3'd3: case (v)
          3'd0: r = {16'h0481, 16'h1008, 16'h8040};
          3'd1: r = {16'h1010, 16'h8080, 16'h0404};
          3'd2: r = {16'h1000, 16'h0040, 16'h0400};
          3'd3: r = {16'h5555, 16'h2222, 16'hFFFF};
          3'd4: r = {16'h4040, 16'h0808, 16'h0400};
          3'd5: r = {16'h0000, 16'h4000, 16'h0080};
          3'd6: r = {16'h0001, 16'h0800, 16'h0000};
          default: r = {16'h0404, 16'h4040, 16'h0808};
        endcase
        3'd4: case (v)
          3'd0: r = {16'h0101, 16'h0400, 16'h8040};
          3'd1: r = {16'h1010, 16'h4000, 16'h0400};
          3'd2: r = {16'h0000, 16'h0080, 16'h0000};
          3'd3: r = {16'h5555, 16'hAAAA, 16'hFFFF};
          3'd4: r = {16'h0000, 16'h4040, 16'h0400};
          3'd5: r = {16'h0000, 16'h4000, 16'h9000};
          3'd6: r = {16'h0001, 16'h1000, 16'h0000};
          default: r = {16'h0000, 16'h8000, 16'h0000};
        endcase
        3'd5: case (v)
          3'd0: r = {16'h0441, 16'h0808, 16'h4000};
          3'd1: r = {16'h1010, 16'h8080, 16'h0400};
          3'd2: r = {16'h0000, 16'h0404, 16'h0040};
          3'd3: r = {16'h5555, 16'h2222, 16'hFFFF};
          3'd4: r = {16'h4040, 16'h0808, 16'h2000};
          3'd5: r = {16'h0000, 16'h4000, 16'h0080};
          3'd6: r = {16'h0001, 16'h1000, 16'h0000};
          default: r = {16'h4444, 16'h0808, 16'h2222};
        endcase
        default: case (v)
          3'd0: r = {16'h0101, 16'h4408, 16'h8040};
          3'd1: r = {16'h1010, 16'h8080, 16'h0404};
          3'd2: r = {16'h0000, 16'h0400, 16'h0040};
          3'd3: r = {16'h1111, 16'h4444, 16'hAAAA};
          3'd4: r = {16'h4040, 16'h0808, 16'h0800};
          3'd5: r = {16'h0000, 16'h4000, 16'h0080};
          3'd6: r = {16'h0441, 16'h4000, 16'h0808};
          default: r = {16'h0000, 16'h0404, 16'h4040};
        endcase
      endcase
      return tmpl_row_t'(r);
    end
  endfunction

  function automatic logic [4:0] lane_lookup(input logic ext, input logic [2:0] v);
    logic [4:0] l;
    begin
      l = '0;
      case (v)
        3'd0: l = 5'd0;
        3'd1: l = 5'd2;
        3'd2: l = ext ? 5'd3 : 5'd1;
        3'd3: l = ext ? 5'd6 : 5'd4;
        3'd4: l = ext ? 5'd10 : 5'd6;
        3'd5: l = ext ? 5'd9 : 5'd7;
        3'd6: l = ext ? 5'd15 : 5'd3;
        default: l = ext ? 5'd20 : 5'd9;
      endcase
      return l;
    end
  endfunction

endpackage
`default_nettype wire

// ----- design/dpg_ctrl.sv -----
`default_nettype none
module dpg_ctrl #(
  parameter int MAX_STEPS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [5:0]     total_steps,
  input  wire logic           chances_ready,
  output logic                busy,
  output dpg_pkg::dp_cmd_t    cmd
);
  import dpg_pkg::*;

  localparam int SW = $clog2(MAX_STEPS + 1) + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_ROLL = 4'b0100,
    S_ROW  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [2:0] voice;
  logic [SW-1:0] step;
  logic [SW-1:0] steps_lim;
  logic [SW-1:0] ts_ext;

  assign ts_ext = SW'(total_steps);

  // Clamp the step count to 1..MAX_STEPS
  always_comb begin
    if (total_steps == 6'd0) steps_lim = SW'(1);
    else if (ts_ext > SW'(MAX_STEPS)) steps_lim = SW'(MAX_STEPS);
    else steps_lim = ts_ext;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_PREP;
      S_PREP: if (chances_ready) state_next = S_ROLL;
      S_ROLL: if (step == steps_lim - SW'(1)) state_next = S_ROW;
      S_ROW: begin
        if (voice == 3'(NUM_VOICES - 1)) state_next = S_IDLE;
        else state_next = S_ROLL;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      voice <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          voice <= '0;
          step  <= '0;
        end
        S_ROLL: begin
          if (state_next == S_ROW) step <= '0;
          else step <= step + SW'(1);
        end
        S_ROW: voice <= voice + 3'd1;
        default: ;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  // Drive the datapath commands
  always_comb begin
    cmd.load     = (state == S_IDLE) && start;
    cmd.roll     = (state == S_ROLL);
    cmd.row_done = (state == S_ROW);
    cmd.voice    = voice;
    cmd.step     = 7'(step);
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ROLL |-> step < steps_lim) else $error("step past limit");
  a_row_after_roll: assert property (@(posedge clk) disable iff (rst)
    state == S_ROW |-> $past(state) == S_ROLL) else $error("row without rolls");
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROW && voice == 3'(NUM_VOICES - 1)) |=> state == S_IDLE)
    else $error("extra row");
endmodule
`default_nettype wire

// ----- design/dpg_datapath.sv -----
`default_nettype none
module dpg_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dpg_pkg::dp_cmd_t cmd,
  input  wire logic [31:0]      seed_in,
  input  wire logic [2:0]       style_select,
  input  wire logic [8:0]       density,
  input  wire logic [8:0]       tension_amount,
  input  wire logic             kit_map,
  output logic                  chances_ready,
  output logic                  valid,
  output logic [4:0]            lane,
  output logic [31:0]           step_mask,
  output logic                  last_row
);
  import dpg_pkg::*;

  // Chance-setup sequencer: numerator phases, then seven divides by 100
  logic [3:0]  phase;
  logic [8:0]  d, t;
  logic [2:0]  st;
  logic [31:0] s;
  logic [31:0] mask;
  logic [17:0] prod;
  logic [31:0] num_a, num_t, num_f, lift;
  logic [24:0] ch_a, ch_t, ch_f, ch_al, ch_tl, ch_fl, ch_0l;

  // Division by 100: latch a numerator, then one reciprocal multiply
  logic [2:0]  dv_sel;
  logic [31:0] dv_num;
  logic [63:0] dv_prod;
  logic [26:0] dv_quo;
  logic [24:0] q_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      dv_sel <= '0;
      chances_ready <= 1'b0;
    end else if (cmd.load) begin
      phase <= 4'd1;
      dv_sel <= '0;
      chances_ready <= 1'b0;
    end else begin
      case (phase)
        4'd1: phase <= 4'd2;
        4'd2: phase <= 4'd3;
        4'd3: phase <= 4'd4;
        4'd4: phase <= 4'd5;
        4'd5: phase <= 4'd6;
        4'd6: phase <= 4'd7;
        4'd7: begin
          // advance to the next divide, or finish after the seventh
          if (dv_sel == 3'd6) begin
            phase <= 4'd8;
            chances_ready <= 1'b1;
          end else begin
            dv_sel <= dv_sel + 3'd1;
            phase <= 4'd6;
          end
        end
        default: ;
      endcase
    end
  end

  // Pick the numerator for the next divide
  always_ff @(posedge clk) begin
    if (phase == 4'd6) begin
      case (dv_sel)
        3'd0: dv_num <= num_a;
        3'd1: dv_num <= num_t;
        3'd2: dv_num <= num_f;
        3'd3: dv_num <= num_a + lift;
        3'd4: dv_num <= num_t + lift;
        3'd5: dv_num <= num_f + lift;
        default: dv_num <= lift;
      endcase
    end
  end

  assign dv_prod = 64'(dv_num) * 64'(DIV100_MUL);
  assign dv_quo  = 27'(dv_prod >> 37);
  assign q_sat   = (dv_quo > 27'(ONE24)) ? ONE24 : dv_quo[24:0];

  // Store each quotient as it finishes
  always_ff @(posedge clk) begin
    if (phase == 4'd7) begin
      case (dv_sel)
        3'd0: ch_a  <= q_sat;
        3'd1: ch_t  <= q_sat;
        3'd2: ch_f  <= q_sat;
        3'd3: ch_al <= q_sat;
        3'd4: ch_tl <= q_sat;
        3'd5: ch_fl <= q_sat;
        default: ch_0l <= q_sat;
      endcase
    end
  end

  // Numerators: products computed over phases 1 to 5, registered between
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d  <= (density > 9'd256) ? 9'd256 : density;
      t  <= (tension_amount > 9'd256) ? 9'd256 : tension_amount;
      st <= (style_select > 3'd5) ? 3'd0 : style_select;
    end
    case (phase)
      4'd1: begin
        num_a <= {16'd13312 + 16'(d) * 16'd46, 16'd0};
        prod  <= 18'd2048 + 18'(t) * 18'd72;
      end
      4'd2: begin
        num_t <= {24'(prod) * 24'(d), 8'd0};
        prod  <= 18'(d) * 18'(d);
      end
      4'd3: lift <= {3'd0, 18'(d) * 18'(t), 11'd0};
      4'd5: num_f <= {2'd0, 30'(prod) * 30'(14'd1536 + 14'(t) * 14'd34)};
      default: ;
    endcase
  end

  // Generator step
  logic [31:0] x1, x2, x3;
  assign x1 = s ^ (s << 13);
  assign x2 = x1 ^ (x1 >> 17);
  assign x3 = x2 ^ (x2 << 5);

  tmpl_row_t row;
  logic [3:0] slot;
  logic [24:0] chance;
  logic lifted;
  assign row = tmpl_lookup(st, cmd.voice);
  assign slot = cmd.step[3:0];
  assign lifted = (cmd.step >= 7'(PHRASE_LEN)) && (slot >= 4'(PHRASE_LEN - 4));

  always_comb begin
    if (row.anchor[slot]) chance = lifted ? ch_al : ch_a;
    else if (row.tension[slot]) chance = lifted ? ch_tl : ch_t;
    else if (row.fill[slot]) chance = lifted ? ch_fl : ch_f;
    else chance = lifted ? ch_0l : 25'd0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) s <= (seed_in == 32'd0) ? SEED_ZERO_SUB : seed_in;
    else if (cmd.roll) s <= x3;
    if (cmd.load || cmd.row_done) mask <= '0;
    else if (cmd.roll && cmd.step < 7'd32 && (25'(x3[23:0]) < chance))
      mask[cmd.step[4:0]] <= 1'b1;
  end

  // Output strobe, one cycle per row
  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else valid <= cmd.row_done;
    lane      <= lane_lookup(kit_map, cmd.voice);
    step_mask <= mask;
    last_row  <= (cmd.voice == 3'(NUM_VOICES - 1));
  end

  a_ready_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !chances_ready) else $error("stale chances");
  a_no_roll_unready: assert property (@(posedge clk) disable iff (rst)
    cmd.roll |-> chances_ready) else $error("roll before chances");
  a_valid_row: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(cmd.row_done)) else $error("spurious strobe");
endmodule
`default_nettype wire

// ----- design/drum_pattern_generator.sv -----
`default_nettype none
// Drum pattern generator. Pulse start with a seed while busy is low; the
// block then emits eight rows (kick, snare, clap, closed hat, open hat, tom,
// cymbal, percussion), each on lane/step_mask/last_row for exactly one cycle
// with valid high. The receiver cannot stall. After a request is taken, busy
// stays high through chance setup (numerator phases, then seven divides by
// 100, each a latch then a multiply) and then, for each row, one generator
// roll per step and the row output, with steps being total_steps clamped to
// 1..MAX_STEPS. The last row's strobe comes in the same cycle that busy
// falls. Configuration writes are taken only while busy and
// start are both low.
module drum_pattern_generator #(
  parameter int MAX_STEPS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] seed,
  output logic             busy,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             valid,
  output logic [4:0]       lane,
  output logic [31:0]      step_mask,
  output logic             last_row
);
  import dpg_pkg::*;

  logic [2:0] style_select;
  logic [8:0] density, tension_amount;
  logic       kit_map;
  logic [5:0] total_steps;
  logic       chances_ready;
  dp_cmd_t    cmd;

  // Hold off writes while a request is taken or in progress
  assign cfg_ready = !busy && !start;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      style_select   <= 3'd0;
      density        <= 9'd128;
      tension_amount <= 9'd128;
      kit_map        <= 1'b0;
      total_steps    <= 6'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STYLE:   style_select   <= cfg_data[2:0];
        REG_DENSITY: density        <= cfg_data[8:0];
        REG_TENSION: tension_amount <= cfg_data[8:0];
        REG_KIT:     kit_map        <= cfg_data[0];
        REG_STEPS:   total_steps    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  dpg_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
    .clk, .rst, .start, .total_steps, .chances_ready, .busy, .cmd
  );

  dpg_datapath u_dp (
    .clk, .rst, .cmd, .seed_in(seed), .style_select, .density, .tension_amount,
    .kit_map, .chances_ready, .valid, .lane, .step_mask, .last_row
  );
endmodule
`default_nettype wire
